// ----- rtl/lprd_pkg.sv -----
`timescale 1ns / 1ps

package lprd_pkg;

    // Register reset values
    localparam logic [31:0] MAX_FRAME_LEN_RST = 32'(32 << 20);
    localparam logic [23:0] MAX_ARG_COUNT_RST = 24'(200 * 1000);

    // Configuration register indexes
    localparam logic CFG_MAX_FRAME_LEN = 1'b0;
    localparam logic CFG_MAX_ARG_COUNT = 1'b1;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_FRAME_LEN = 3'd1;
    localparam logic [2:0] ERR_ARG_COUNT = 3'd2;
    localparam logic [2:0] ERR_OVERRUN   = 3'd3;
    localparam logic [2:0] ERR_TRAILING  = 3'd4;

    // Output tdata layout
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        is_payload;
        logic [23:0] arg_index;
        logic        arg_done;
        logic        frame_done;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ----- rtl/length_prefixed_request_deframer_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Ports                              Content
// s_*       in         s_tvalid s_tready s_tdata[7:0]     one request byte
// m_*       out        m_tvalid m_tready m_tdata m_tuser  parse result of that byte
//                      m_tlast
// cfg_*     in         cfg_valid cfg_ready cfg_index      register write
//                      cfg_data
//
// One byte is taken per cycle while s_tready is high; its result appears in the output
// register in the next cycle. The per-byte update (word assembly, compares, subtracts)
// is done by the logic between the parser state registers and the output register.
// s_tready is low only while a result sits in the output register and m_tready is low.
// rst_n clears the parser state, the sticky error and the limits to their defaults.
// cfg_ready is always high; writes take effect on the next byte.

module length_prefixed_request_deframer_core
    import lprd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] byte_value, [31:8] arg_index, [32] arg_done, [35:33] error_code, [39:36] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,   // [0] is_payload
    output logic                   m_tlast,   // frame_done
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam logic [1:0] PH_FRAME_LEN = 2'd0;
    localparam logic [1:0] PH_ARG_COUNT = 2'd1;
    localparam logic [1:0] PH_ARG_LEN   = 2'd2;
    localparam logic [1:0] PH_ARG_DATA  = 2'd3;

    logic [31:0] max_frame_len_reg;
    logic [23:0] max_arg_count_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  wcnt_reg, wcnt_next;
    logic [31:0] wshift_reg, wshift_next;
    logic [31:0] fbl_reg, fbl_next;
    logic [23:0] args_reg, args_next;
    logic [31:0] abl_reg, abl_next;
    logic [23:0] cur_reg, cur_next;
    logic [2:0]  err_reg, err_next;

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res;

    logic        s_accept;
    logic [31:0] word;
    logic [31:0] abl_dec;
    logic        take_next;
    logic [23:0] args_n;
    logic [31:0] fbl_n;

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign word    = {s_tdata, wshift_reg[23:0]};
    assign abl_dec = (abl_reg != 32'd0) ? abl_reg - 32'd1 : abl_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        wcnt_next   = wcnt_reg;
        wshift_next = wshift_reg;
        fbl_next    = fbl_reg;
        args_next   = args_reg;
        abl_next    = abl_reg;
        cur_next    = cur_reg;
        err_next    = err_reg;
        take_next   = 1'b0;
        args_n      = args_reg;
        fbl_n       = fbl_reg;

        res.byte_value = s_tdata;
        res.is_payload = 1'b0;
        res.arg_index  = '0;
        res.arg_done   = 1'b0;
        res.frame_done = 1'b0;
        res.error_code = ERR_NONE;

        if (err_reg == ERR_NONE)
        begin
            if (phase_reg == PH_ARG_DATA)
            begin
                res.is_payload = 1'b1;
                res.arg_index  = cur_reg;
                abl_next       = abl_dec;
                if (abl_dec == 32'd0)
                begin
                    res.arg_done = 1'b1;
                    cur_next     = cur_reg + 24'd1;
                    args_n       = args_reg - 24'd1;
                    args_next    = args_n;
                    take_next    = 1'b1;
                end
            end
            else
            begin
                if (phase_reg == PH_ARG_LEN)
                begin
                    res.arg_index = cur_reg;
                end
                if (wcnt_reg != 2'd3)
                begin
                    wcnt_next   = wcnt_reg + 2'd1;
                    wshift_next = wshift_reg | ({24'd0, s_tdata} << {wcnt_reg, 3'b000});
                end
                else
                begin
                    wcnt_next   = 2'd0;
                    wshift_next = '0;
                    case (phase_reg)
                        PH_ARG_COUNT:
                        begin
                            if (word > {8'd0, max_arg_count_reg})
                            begin
                                err_next = ERR_ARG_COUNT;
                            end
                            else
                            begin
                                args_n    = word[23:0];
                                args_next = args_n;
                                cur_next  = '0;
                                take_next = 1'b1;
                            end
                        end
                        PH_ARG_LEN:
                        begin
                            if (word > fbl_reg)
                            begin
                                err_next = ERR_OVERRUN;
                            end
                            else if (word == 32'd0)
                            begin
                                // empty argument: done on its length field
                                res.arg_done = 1'b1;
                                cur_next     = cur_reg + 24'd1;
                                args_n       = args_reg - 24'd1;
                                args_next    = args_n;
                                take_next    = 1'b1;
                            end
                            else
                            begin
                                fbl_next   = fbl_reg - word;
                                abl_next   = word;
                                phase_next = PH_ARG_DATA;
                            end
                        end
                        default:
                        begin
                            if (word > max_frame_len_reg)
                            begin
                                err_next = ERR_FRAME_LEN;
                            end
                            else if (word < 32'd4)
                            begin
                                err_next = ERR_OVERRUN;
                            end
                            else
                            begin
                                fbl_next   = word - 32'd4;
                                phase_next = PH_ARG_COUNT;
                            end
                        end
                    endcase
                end
            end

            // close the frame, open the next length field, or flag trailing data or an overrun
            if (take_next)
            begin
                if (args_n == 24'd0)
                begin
                    if (fbl_n == 32'd0)
                    begin
                        phase_next     = PH_FRAME_LEN;
                        cur_next       = '0;
                        res.frame_done = 1'b1;
                    end
                    else
                    begin
                        err_next = ERR_TRAILING;
                    end
                end
                else if (fbl_n < 32'd4)
                begin
                    err_next = ERR_OVERRUN;
                end
                else
                begin
                    fbl_next   = fbl_n - 32'd4;
                    phase_next = PH_ARG_LEN;
                end
            end
        end

        if (err_next != ERR_NONE)
        begin
            res.is_payload = 1'b0;
            res.arg_index  = '0;
            res.arg_done   = 1'b0;
            res.frame_done = 1'b0;
        end
        res.error_code = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_len_reg <= MAX_FRAME_LEN_RST;
            max_arg_count_reg <= MAX_ARG_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_FRAME_LEN)
            begin
                max_frame_len_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAX_ARG_COUNT)
            begin
                max_arg_count_reg <= cfg_data[23:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FRAME_LEN;
            wcnt_reg   <= '0;
            wshift_reg <= '0;
            fbl_reg    <= '0;
            args_reg   <= '0;
            abl_reg    <= '0;
            cur_reg    <= '0;
            err_reg    <= ERR_NONE;
        end
        else if (s_accept)
        begin
            phase_reg  <= phase_next;
            wcnt_reg   <= wcnt_next;
            wshift_reg <= wshift_next;
            fbl_reg    <= fbl_next;
            args_reg   <= args_next;
            abl_reg    <= abl_next;
            cur_reg    <= cur_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.error_code, out_reg.arg_done,
                       out_reg.arg_index, out_reg.byte_value};
    assign m_tuser  = out_reg.is_payload;
    assign m_tlast  = out_reg.frame_done;

    // hold the error once raised
    a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ERR_NONE |=> err_reg == $past(err_reg))
        else $error("sticky error changed");

    // silence all flags once an error is reported
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[35:33] != ERR_NONE |-> !m_tuser && !m_tlast && !m_tdata[32])
        else $error("flags set alongside error");

    // payload bytes never interleave with a partial header word
    a_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ARG_DATA |-> wcnt_reg == 2'd0)
        else $error("partial word during argument data");

    // restart header parsing after a completed frame
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && res.frame_done |=> phase_reg == PH_FRAME_LEN && cur_reg == 24'd0)
        else $error("frame end did not restart parser");

    // payload never reported outside the data phase
    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && res.is_payload |-> phase_reg == PH_ARG_DATA)
        else $error("payload outside argument data");

endmodule

// ----- sim/lprd_result_check.sv -----
`timescale 1ns / 1ps

module lprd_result_check
    import lprd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser,
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     fail_count,
    output int                     outstanding,
    output int                     frames_closed
);

    typedef enum logic [2:0] {
        ST_FRAME_LEN,
        ST_ARG_COUNT,
        ST_ARG_LEN,
        ST_ARG_DATA,
        ST_HALT
    } parse_state_e;

    // Shadow copy of the parser state and limits
    parse_state_e parse_state;
    logic [1:0]   byte_pos;
    logic [31:0]  word_acc;
    logic [31:0]  body_left;
    logic [23:0]  args_left;
    logic [31:0]  arg_left;
    logic [23:0]  arg_num;
    logic [2:0]   fault;
    logic [31:0]  frame_limit;
    logic [23:0]  arg_limit;

    result_t predicted_results[$];
    result_t got;
    result_t want;

    function automatic void raise_fault(input logic [2:0] code);
        fault       = code;
        parse_state = ST_HALT;
    endfunction

    // After count or argument: close the frame, open the next length field or fault.
    function automatic logic end_of_item();
        if (args_left == 24'd0)
        begin
            if (body_left == 32'd0)
            begin
                parse_state = ST_FRAME_LEN;
                arg_num     = 24'd0;
                return 1'b1;
            end
            raise_fault(ERR_TRAILING);
            return 1'b0;
        end
        if (body_left < 32'd4)
        begin
            raise_fault(ERR_OVERRUN);
            return 1'b0;
        end
        body_left   = body_left - 32'd4;
        parse_state = ST_ARG_LEN;
        return 1'b0;
    endfunction

    function automatic logic close_arg();
        arg_num   = arg_num + 24'd1;
        args_left = args_left - 24'd1;
        return end_of_item();
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t     r;
        logic [31:0] w;
        r            = '0;
        r.byte_value = b;
        if (fault == ERR_NONE)
        begin
            if (parse_state == ST_ARG_DATA)
            begin
                r.is_payload = 1'b1;
                r.arg_index  = arg_num;
                if (arg_left != 32'd0)
                    arg_left = arg_left - 32'd1;
                if (arg_left == 32'd0)
                begin
                    r.arg_done   = 1'b1;
                    r.frame_done = close_arg();
                end
            end
            else
            begin
                if (parse_state == ST_ARG_LEN)
                    r.arg_index = arg_num;
                word_acc = word_acc | ({24'd0, b} << (8 * byte_pos));
                if (byte_pos != 2'd3)
                    byte_pos = byte_pos + 2'd1;
                else
                begin
                    byte_pos = 2'd0;
                    w        = word_acc;
                    word_acc = 32'd0;
                    case (parse_state)
                        ST_ARG_COUNT:
                        begin
                            if (w > {8'd0, arg_limit})
                                raise_fault(ERR_ARG_COUNT);
                            else
                            begin
                                args_left    = w[23:0];
                                arg_num      = 24'd0;
                                r.frame_done = end_of_item();
                            end
                        end
                        ST_ARG_LEN:
                        begin
                            if (w > body_left)
                                raise_fault(ERR_OVERRUN);
                            else
                            begin
                                body_left = body_left - w;
                                if (w == 32'd0)
                                begin
                                    r.arg_done   = 1'b1;
                                    r.frame_done = close_arg();
                                end
                                else
                                begin
                                    arg_left    = w;
                                    parse_state = ST_ARG_DATA;
                                end
                            end
                        end
                        default:
                        begin
                            if (w > frame_limit)
                                raise_fault(ERR_FRAME_LEN);
                            else if (w < 32'd4)
                                raise_fault(ERR_OVERRUN);
                            else
                            begin
                                body_left   = w - 32'd4;
                                parse_state = ST_ARG_COUNT;
                            end
                        end
                    endcase
                end
            end
        end
        if (fault != ERR_NONE)
        begin
            r.is_payload = 1'b0;
            r.arg_index  = 24'd0;
            r.arg_done   = 1'b0;
            r.frame_done = 1'b0;
        end
        r.error_code = fault;
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state   = ST_FRAME_LEN;
            byte_pos      = 2'd0;
            word_acc      = 32'd0;
            body_left     = 32'd0;
            args_left     = 24'd0;
            arg_left      = 32'd0;
            arg_num       = 24'd0;
            fault         = ERR_NONE;
            frame_limit   = MAX_FRAME_LEN_RST;
            arg_limit     = MAX_ARG_COUNT_RST;
            fail_count    = 0;
            outstanding   = 0;
            frames_closed = 0;
            predicted_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.byte_value = m_tdata[7:0];
                got.arg_index  = m_tdata[31:8];
                got.arg_done   = m_tdata[32];
                got.error_code = m_tdata[35:33];
                got.is_payload = m_tuser;
                got.frame_done = m_tlast;
                if (m_tlast)
                    frames_closed++;
                if (predicted_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request pending, expected none, actual 0x%0h",
                             $time, got);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
                    compare_field("is_payload", 32'(want.is_payload), 32'(got.is_payload));
                    compare_field("arg_index",  32'(want.arg_index),  32'(got.arg_index));
                    compare_field("arg_done",   32'(want.arg_done),   32'(got.arg_done));
                    compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                    compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
                end
            end
            // a request taken on this edge still sees the old limits
            if (s_tvalid && s_tready)
                predicted_results.insert(predicted_results.size(), parse_byte(s_tdata));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAX_FRAME_LEN)
                    frame_limit = cfg_data;
                else
                    arg_limit = cfg_data[23:0];
            end
            outstanding = predicted_results.size();
        end
    end

endmodule

// ----- sim/length_prefixed_request_deframer_core_tb.sv -----
`timescale 1ns / 1ps

module length_prefixed_request_deframer_core_tb;
    import lprd_pkg::*;

    typedef enum {
        BREAK_LONG_FRAME,
        BREAK_TOO_MANY_ARGS,
        BREAK_SHORT_FRAME,
        BREAK_ARG_OVERRUN,
        BREAK_NO_ROOM,
        BREAK_TRAILING
    } break_kind_e;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = CFG_MAX_FRAME_LEN;
    logic [31:0]            cfg_data  = 32'd0;

    int check_fails;
    int results_pending;
    int frames_closed;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          requests_sent = 0;
    int          settings_used = 0;
    logic [31:0] lim_frame     = MAX_FRAME_LEN_RST;
    logic [23:0] lim_args      = MAX_ARG_COUNT_RST;
    logic [7:0]  stream_q[$];
    break_kind_e break_kind;

    always #5 clk = ~clk;

    length_prefixed_request_deframer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lprd_result_check result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (check_fails),
        .outstanding   (results_pending),
        .frames_closed (frames_closed)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    initial
    begin
        #5_000_000;
        $display("length_prefixed_request_deframer_core_tb: errors");
        $finish;
    end

    task automatic append_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endtask

    task automatic queue_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            append_byte(w[8*i +: 8]);
    endtask

    // Build one well-formed frame that fits the current limits.
    task automatic queue_frame();
        int arg_cap;
        int len_cap;
        int n;
        int room;
        int len;
        int body_len;
        int lens[$];
        arg_cap  = (lim_args > 6) ? 6 : int'(lim_args);
        len_cap  = (lim_frame > 200) ? 200 : int'(lim_frame);
        n        = $urandom_range(0, arg_cap);
        if (n > (len_cap - 4) / 4)
            n = (len_cap - 4) / 4;
        room     = len_cap - 4 - 4 * n;
        body_len = 4 + 4 * n;
        for (int i = 0; i < n; i++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            // under a tight limit, fill the frame exactly to the limit now and then
            if (i == n - 1 && len_cap <= 64 && $urandom_range(0, 3) == 0)
                len = room;
            if (len > room)
                len = room;
            room     -= len;
            body_len += len;
            lens.insert(lens.size(), len);
        end
        queue_word(body_len);
        queue_word(n);
        foreach (lens[i])
        begin
            queue_word(lens[i]);
            repeat (lens[i])
                append_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_stream();
        logic [7:0] b;
        while (stream_q.size() != 0)
        begin
            b = stream_q.pop_front();
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            do @(posedge clk); while (!s_tready);
            requests_sent++;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_MAX_FRAME_LEN)
            lim_frame = val;
        else
            lim_args = val[23:0];
    endtask

    task automatic settle();
        do @(posedge clk); while (results_pending != 0);
    endtask

    task automatic apply_limits(input int setting);
        case (setting)
            0:
            begin
                write_reg(CFG_MAX_FRAME_LEN, 32'hFFFF_FFFF);
                write_reg(CFG_MAX_ARG_COUNT, 32'h00FF_FFFF);
            end
            1:
            begin
                write_reg(CFG_MAX_FRAME_LEN, 32'd64);
                write_reg(CFG_MAX_ARG_COUNT, 32'd4);
            end
            2:
            begin
                // only empty frames fit
                write_reg(CFG_MAX_FRAME_LEN, 32'd4);
                write_reg(CFG_MAX_ARG_COUNT, 32'd0);
            end
            default:
            begin
                write_reg(CFG_MAX_FRAME_LEN, MAX_FRAME_LEN_RST);
                write_reg(CFG_MAX_ARG_COUNT, {8'd0, MAX_ARG_COUNT_RST});
            end
        endcase
        settings_used++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 84; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
        endcase
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty frame, then a frame with an empty argument and a one-byte argument
        queue_word(32'd4);
        queue_word(32'd0);
        queue_word(32'd13);
        queue_word(32'd2);
        queue_word(32'd0);
        queue_word(32'd1);
        append_byte(8'hFF);
        send_stream();
        settle();

        for (int k = 0; k < 8; k++)
        begin
            apply_limits(k % 4);
            set_idling((k + k / 4) % 4);
            while (stream_q.size() < 250)
                queue_frame();
            send_stream();
            settle();
        end

        // Close with one broken request; the fault must then stick.
        set_idling(3);
        break_kind = break_kind_e'($urandom_range(0, 5));
        case (break_kind)
            BREAK_LONG_FRAME:
            begin
                write_reg(CFG_MAX_FRAME_LEN, 32'd0);
                queue_word($urandom() | 32'd1);
            end
            BREAK_TOO_MANY_ARGS:
            begin
                write_reg(CFG_MAX_ARG_COUNT, 32'd0);
                queue_word(32'd8);
                queue_word($urandom_range(1, 5));
            end
            BREAK_SHORT_FRAME:
                queue_word($urandom_range(0, 3));
            BREAK_ARG_OVERRUN:
            begin
                queue_word(32'd12);
                queue_word(32'd1);
                queue_word(32'd5);
            end
            BREAK_NO_ROOM:
            begin
                queue_word(32'd5);
                queue_word(32'd1);
            end
            default:
            begin
                queue_word(32'd9);
                queue_word(32'd0);
            end
        endcase
        repeat (24)
            append_byte(8'($urandom_range(0, 255)));
        send_stream();
        settle();
        repeat (4) @(posedge clk);

        $display("run covered %0d request bytes, %0d clean frames, %0d limit settings",
                 requests_sent, frames_closed, settings_used);
        $display("final fault %s", break_kind.name());
        if (check_fails == 0)
            $display("length_prefixed_request_deframer_core_tb: clean");
        else
            $display("length_prefixed_request_deframer_core_tb: errors");
        $finish;
    end

endmodule

// ----- length_prefixed_request_deframer_core.f -----
rtl/lprd_pkg.sv
rtl/length_prefixed_request_deframer_core.sv
sim/lprd_result_check.sv
sim/length_prefixed_request_deframer_core_tb.sv
